// ===== rtl/core/mrrb_pkg.sv =====
// mrrb_pkg: shared types and codes for the multi-reader ring buffer.
// No dependencies.
`timescale 1ns / 1ps
package mrrb_pkg;
  typedef enum logic [2:0] {
    FN_CREATE = 3'd0,
    FN_WRITE  = 3'd1,
    FN_READ   = 3'd2,
    FN_FLUSH  = 3'd3,
    FN_FORK   = 3'd4,
    FN_CLOSE  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ACCESS = 2'd1,
    ST_CLOSED = 2'd2,
    ST_OTHER  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_WAIT  = 2'd1,
    BK_OUT   = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        file_end;
    logic [15:0] pid;
    logic [15:0] parent_pid;
    logic [7:0]  data_byte;
    logic        last_of_call;
  } item_t;
endpackage

// ===== rtl/core/multi_reader_ring_buffer_unit.sv =====
// multi_reader_ring_buffer_unit: top level of the multi-reader ring buffer.
// Depends on mrrb_pkg, mrrb_front, mrrb_back, mrrb_ram.
`timescale 1ns / 1ps
// A byte ring shared by up to CLIENT_SLOTS clients, one request byte per
// transfer and exactly one result per transfer, in order. A two-entry queue
// in front takes new transfers while the back end works or its result waits
// to be taken. The back end handles one item at a time in turn: pop,
// execute with slot lookup and ring access, present result; it pops the
// next item only after the result has been taken. No clearing pass
// after reset: ring entries are only read after they were written.
module multi_reader_ring_buffer_unit #(
  parameter int BUFFER_BYTES = 4096,
  parameter int CLIENT_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic        file_end,
  input  logic [15:0] pid,
  input  logic [15:0] parent_pid,
  input  logic [7:0]  data_byte,
  input  logic        last_of_call,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic        moved,
  output logic [12:0] reclaimed,
  output logic        last_out
);
  mrrb_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  // bundle the request fields for the queue
  assign in_item = '{func: func, file_end: file_end, pid: pid,
                     parent_pid: parent_pid, data_byte: data_byte,
                     last_of_call: last_of_call};

  mrrb_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  mrrb_back #(.BUFFER_BYTES(BUFFER_BYTES), .CLIENT_SLOTS(CLIENT_SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(status),
    .out_read_byte(read_byte), .out_moved(moved), .out_reclaimed(reclaimed),
    .out_last(last_out)
  );

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !q_pop)
    else $error("new item popped while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !moved) |-> read_byte == 8'd0)
    else $error("byte shown without a read");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && reclaimed != 13'd0) |-> status == mrrb_pkg::ST_OK)
    else $error("reclaim reported with error");
endmodule

// ===== rtl/core/mrrb_ram.sv =====
// mrrb_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mrrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/mrrb_front.sv =====
// mrrb_front: two-entry queue toward the back end.
// Depends on mrrb_pkg.
`timescale 1ns / 1ps
module mrrb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mrrb_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output mrrb_pkg::item_t q_item
);
  mrrb_pkg::item_t entry [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) entry[wr_ptr] <= in_item;
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |=> count == 2'd2)
    else $error("full queue lost an entry");
endmodule

// ===== rtl/core/mrrb_back.sv =====
// mrrb_back: slot table, pointers and ring memory; executes one item at a time.
// Depends on mrrb_pkg and mrrb_ram.
`timescale 1ns / 1ps
module mrrb_back #(
  parameter int BUFFER_BYTES = 4096,
  parameter int CLIENT_SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  mrrb_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_read_byte,
  output logic            out_moved,
  output logic [12:0]     out_reclaimed,
  output logic            out_last
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_BYTES - 1);
  localparam logic [CW-1:0] FULL     = CW'(BUFFER_BYTES);

  logic [AW-1:0] write_pointer;
  logic [CW-1:0] occupancy;
  logic [15:0]   slot_pid   [CLIENT_SLOTS];
  logic [CLIENT_SLOTS-1:0] slot_valid, slot_read_open, slot_write_open;
  logic [AW-1:0] slot_read_pointer [CLIENT_SLOTS];
  logic [CW-1:0] slot_unread [CLIENT_SLOTS];

  mrrb_pkg::back_state_t state, state_next;
  mrrb_pkg::item_t cur;

  // lookup results for the current item
  logic          hit_pid, hit_par, any_free, any_ro;
  logic [SW-1:0] sidx, pidx, fidx;
  logic [CW-1:0] mx;

  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic          rd_pending;

  logic [1:0]    res_status;
  logic          res_moved;
  logic [12:0]   res_recl;

  mrrb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ring (
    .clk(clk), .we(ram_we), .waddr(write_pointer), .wdata(cur.data_byte),
    .raddr(slot_read_pointer[sidx]), .rdata(ram_rdata)
  );

  // lookup combinational (two pid compares per slot, one max tree)
  always_comb begin
    hit_pid = 1'b0; hit_par = 1'b0; any_free = 1'b0; any_ro = 1'b0;
    sidx = '0; pidx = '0; fidx = '0; mx = '0;
    for (int k = CLIENT_SLOTS - 1; k >= 0; k--) begin
      if (slot_valid[k] && slot_pid[k] == cur.pid) begin
        hit_pid = 1'b1; sidx = SW'(k);
      end
      if (slot_valid[k] && slot_pid[k] == cur.parent_pid) begin
        hit_par = 1'b1; pidx = SW'(k);
      end
      if (!slot_valid[k]) begin
        any_free = 1'b1; fidx = SW'(k);
      end
    end
    for (int k = 0; k < CLIENT_SLOTS; k++) begin
      if (slot_valid[k] && slot_read_open[k]) begin
        any_ro = 1'b1;
        if (slot_unread[k] > mx) mx = slot_unread[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mrrb_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      mrrb_pkg::BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = mrrb_pkg::BK_WAIT;
      end
      mrrb_pkg::BK_WAIT: state_next = mrrb_pkg::BK_OUT;
      mrrb_pkg::BK_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = mrrb_pkg::BK_IDLE;
      end
      default: state_next = mrrb_pkg::BK_IDLE;
    endcase
  end

  // execute at BK_WAIT with the lookup of the item loaded at the pop
  logic exec;
  assign exec = (state == mrrb_pkg::BK_WAIT);
  assign ram_we = exec && cur.func == mrrb_pkg::FN_WRITE && cur.file_end
                  && hit_pid && slot_write_open[sidx] && occupancy < FULL;

  always_ff @(posedge clk) begin
    logic open_left;
    logic [CLIENT_SLOTS-1:0] ro_n, wo_n;
    if (q_pop) cur <= q_item;
    if (rst) begin
      write_pointer <= '0; occupancy <= '0;
      slot_valid <= '0; slot_read_open <= '0; slot_write_open <= '0;
      for (int k = 0; k < CLIENT_SLOTS; k++) begin
        slot_pid[k] <= '0; slot_read_pointer[k] <= '0; slot_unread[k] <= '0;
      end
      rd_pending <= 1'b0;
    end else if (exec) begin
      res_status <= mrrb_pkg::ST_OK;
      res_moved  <= 1'b0;
      res_recl   <= '0;
      rd_pending <= 1'b0;
      unique case (cur.func)
        mrrb_pkg::FN_CREATE: begin
          write_pointer <= '0; occupancy <= '0;
          slot_valid <= '0; slot_read_open <= '0; slot_write_open <= '0;
          for (int k = 0; k < CLIENT_SLOTS; k++) begin
            slot_pid[k] <= '0; slot_read_pointer[k] <= '0; slot_unread[k] <= '0;
          end
          slot_valid[0] <= 1'b1; slot_pid[0] <= cur.pid;
          slot_read_open[0] <= 1'b1; slot_write_open[0] <= 1'b1;
        end
        mrrb_pkg::FN_WRITE: begin
          if (!cur.file_end) res_status <= mrrb_pkg::ST_ACCESS;
          else if (!hit_pid || !slot_write_open[sidx])
            res_status <= mrrb_pkg::ST_CLOSED;
          else if (occupancy < FULL) begin
            write_pointer <= (write_pointer == LAST_POS) ? '0 : write_pointer + 1'b1;
            occupancy <= occupancy + 1'b1;
            for (int k = 0; k < CLIENT_SLOTS; k++)
              if (slot_valid[k] && slot_unread[k] < FULL)
                slot_unread[k] <= slot_unread[k] + 1'b1;
            res_moved <= 1'b1;
          end
        end
        mrrb_pkg::FN_READ: begin
          if (cur.file_end) res_status <= mrrb_pkg::ST_ACCESS;
          else if (!hit_pid || !slot_read_open[sidx])
            res_status <= mrrb_pkg::ST_CLOSED;
          else if (slot_unread[sidx] != '0) begin
            slot_read_pointer[sidx] <= (slot_read_pointer[sidx] == LAST_POS) ? '0
                                       : slot_read_pointer[sidx] + 1'b1;
            slot_unread[sidx] <= slot_unread[sidx] - 1'b1;
            res_moved <= 1'b1;
            rd_pending <= 1'b1;
          end
        end
        mrrb_pkg::FN_FLUSH: begin
          if (any_ro && mx <= occupancy) begin
            res_recl  <= 13'(occupancy - mx);
            occupancy <= mx;
          end
        end
        mrrb_pkg::FN_FORK: begin
          if (!hit_pid) begin
            if (!hit_par || !any_free) res_status <= mrrb_pkg::ST_OTHER;
            else begin
              slot_valid[fidx] <= 1'b1; slot_pid[fidx] <= cur.pid;
              slot_read_open[fidx] <= slot_read_open[pidx];
              slot_write_open[fidx] <= slot_write_open[pidx];
              slot_read_pointer[fidx] <= slot_read_pointer[pidx];
              slot_unread[fidx] <= slot_unread[pidx];
            end
          end
        end
        mrrb_pkg::FN_CLOSE: begin
          ro_n = slot_read_open; wo_n = slot_write_open;
          if (!hit_pid) res_status <= mrrb_pkg::ST_OTHER;
          else if (cur.file_end ? !wo_n[sidx] : !ro_n[sidx])
            res_status <= mrrb_pkg::ST_OTHER;
          else begin
            if (cur.file_end) wo_n[sidx] = 1'b0;
            else              ro_n[sidx] = 1'b0;
            slot_read_open <= ro_n; slot_write_open <= wo_n;
            if (!ro_n[sidx] && !wo_n[sidx]) begin
              slot_valid[sidx] <= 1'b0; slot_pid[sidx] <= '0;
              slot_read_pointer[sidx] <= '0; slot_unread[sidx] <= '0;
            end
            open_left = |(slot_valid & (ro_n | wo_n));
            if (!open_left) begin
              write_pointer <= '0; occupancy <= '0;
              slot_valid <= '0; slot_read_open <= '0; slot_write_open <= '0;
              for (int k = 0; k < CLIENT_SLOTS; k++) begin
                slot_pid[k] <= '0; slot_read_pointer[k] <= '0;
                slot_unread[k] <= '0;
              end
            end
          end
        end
        default: res_status <= mrrb_pkg::ST_OTHER;
      endcase
    end
  end

  // RAM read is registered in the BK_WAIT edge; data valid in BK_OUT.
  logic byte_live;
  always_ff @(posedge clk) begin
    if (rst) byte_live <= 1'b0;
    else     byte_live <= exec;
  end
  logic [7:0] held_byte;
  always_ff @(posedge clk) begin
    if (byte_live) held_byte <= ram_rdata;
  end

  assign out_status    = res_status;
  assign out_moved     = res_moved;
  assign out_reclaimed = res_recl;
  assign out_last      = cur.last_of_call;
  assign out_read_byte = !rd_pending ? 8'd0 : (byte_live ? ram_rdata : held_byte);

  assert property (@(posedge clk) disable iff (rst) occupancy <= FULL)
    else $error("occupancy beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == mrrb_pkg::BK_WAIT)
    else $error("popped item not executed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
endmodule
